FILE: sv/dhcpc_pkg.sv
// dhcp client lease machine package: payload structs, codes and register map
// no dependencies
package dhcpc_pkg;

  localparam int unsigned CfgAw = 5;
  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] InfiniteLease = 32'hFFFF_FFFF;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] DefaultLease = 32'd3600;

  typedef enum logic [1:0] {
    OpTick = 2'd0,
    OpPoll = 2'd1,
    OpInit = 2'd2,
    OpNop  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PhInit = 3'd0,
    PhSelecting = 3'd1,
    PhRequesting = 3'd2,
    PhRebooting = 3'd3,
    PhLeased = 3'd4,
    PhRenewing = 3'd5,
    PhRebinding = 3'd6,
    PhUnused = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindDiscover = 2'd1,
    KindRequest = 2'd2,
    KindDecline = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StRunning = 3'd0,
    StLeased = 3'd1,
    StAssigned = 3'd2,
    StChanged = 3'd3,
    StFailed = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CacheNone = 2'd0,
    CacheSave = 2'd1,
    CacheForget = 2'd2
  } cache_e;

  typedef enum logic [2:0] {
    RegXidSeed = 3'd0,
    RegCachedIp = 3'd1,
    RegCachedSid = 3'd2,
    RegRetryLimit = 3'd3,
    RegRenewResend = 3'd4,
    RegDefaultLease = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  replies_seen;
    logic [31:0] offer_ip;
    logic [31:0] offer_server;
    logic [31:0] ack_ip;
    logic [31:0] ack_server;
    logic        ack_has_server;
    logic [31:0] ack_lease;
    logic [31:0] ack_t1;
    logic [31:0] ack_t2;
    logic        probe_in_use;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  send_kind;
    logic        broadcast_flag;
    logic        unicast_to_server;
    logic [31:0] client_ip_field;
    logic [31:0] requested_ip_option;
    logic [31:0] server_id_option;
    logic [31:0] transaction_id;
    logic [31:0] bound_ip;
    logic [1:0]  cache_action;
  } out_item_t;

  typedef struct packed {
    logic [31:0] xid_seed;
    logic [31:0] cached_ip;
    logic [31:0] cached_sid;
    logic [3:0]  retry_limit;
    logic [7:0]  renew_resend;
    logic [31:0] default_lease;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e         op;
    logic        offer;
    logic        ack;
    logic        nak;
    logic [31:0] offer_ip;
    logic [31:0] offer_server;
    logic [31:0] ack_ip;
    logic [31:0] ack_server;
    logic        ack_has_server;
    logic [31:0] ack_lease;
    logic [31:0] ack_t1;
    logic [31:0] ack_t2;
    logic        probe_in_use;
  } cmd_t;

endpackage

FILE: sv/dhcpc_front.sv
// front end: takes input transactions, decodes them and queues commands
// depends on dhcpc_pkg
module dhcpc_front #(
  parameter int unsigned Depth = dhcpc_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dhcpc_pkg::in_item_t  in_data_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output dhcpc_pkg::cmd_t      cmd_o
);
  import dhcpc_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem_q [Depth];
  logic [Aw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]   cnt_q, cnt_d;
  cmd_t          cmd;
  logic          push, pop;

  always_comb begin
    cmd.op = op_e'(in_data_i.opcode);
    cmd.offer = in_data_i.replies_seen[0];
    cmd.ack = in_data_i.replies_seen[1];
    cmd.nak = in_data_i.replies_seen[2];
    cmd.offer_ip = in_data_i.offer_ip;
    cmd.offer_server = in_data_i.offer_server;
    cmd.ack_ip = in_data_i.ack_ip;
    cmd.ack_server = in_data_i.ack_server;
    cmd.ack_has_server = in_data_i.ack_has_server;
    cmd.ack_lease = in_data_i.ack_lease;
    cmd.ack_t1 = in_data_i.ack_t1;
    cmd.ack_t2 = in_data_i.ack_t2;
    cmd.probe_in_use = in_data_i.probe_in_use;
  end

  assign in_ready_o = (cnt_q != (Aw+1)'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd;
    end
  end

endmodule

FILE: sv/dhcpc_back.sv
// back end: lease state machine, one command per cycle while the output register can drain, registered result
// depends on dhcpc_pkg
module dhcpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dhcpc_pkg::cfg_t      cfg_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  dhcpc_pkg::cmd_t      cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dhcpc_pkg::out_item_t out_data_o
);
  import dhcpc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] now_q, now_d, sent_q, sent_d, xid_q, xid_d;
  logic [3:0]  retry_q, retry_d;
  logic [31:0] offered_q, offered_d, server_q, server_d, lease_q, lease_d;
  logic [31:0] llen_q, llen_d, t1_q, t1_d, t2_q, t2_d, exp_q, exp_d;
  logic        ovalid_q;
  out_item_t   out_q, res;
  logic        take;

  assign cmd_ready_o = !ovalid_q || out_ready_i;
  assign take = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = ovalid_q;
  assign out_data_o = out_q;

  // bind values computed off the incoming ack
  logic [31:0] b_len, b_t1, b_t2, b_exp;
  logic [2:0]  b_status;
  logic [31:0] elapsed, pace;
  logic        tmo_pace, tmo_renew;
  logic [3:0]  retry_inc;

  always_comb begin
    b_len = (cmd_i.ack_lease != '0) ? cmd_i.ack_lease : cfg_i.default_lease;
    if (b_len == InfiniteLease) begin
      b_t1 = InfiniteLease;
      b_t2 = InfiniteLease;
      b_exp = InfiniteLease;
    end else begin
      b_t1 = now_q + ((cmd_i.ack_t1 != '0) ? cmd_i.ack_t1 : {1'b0, b_len[31:1]});
      b_t2 = now_q + ((cmd_i.ack_t2 != '0) ? cmd_i.ack_t2 :
             ({3'b000, b_len[31:3]} * 32'd7));
      b_exp = now_q + b_len;
    end
    if (lease_q != '0 && lease_q != cmd_i.ack_ip) begin
      b_status = StChanged;
    end else if (lease_q == '0) begin
      b_status = StAssigned;
    end else begin
      b_status = StLeased;
    end
    elapsed = now_q - sent_q;
    pace = (retry_q == 4'd0) ? 32'd1 : ((retry_q == 4'd1) ? 32'd2 : 32'd4);
    tmo_pace = elapsed >= pace;
    tmo_renew = elapsed >= {24'd0, cfg_i.renew_resend};
    retry_inc = retry_q + 1'b1;
  end

  logic        snd;
  kind_e       kind;
  logic [31:0] s_req, s_sid;
  phase_e      ph_emit;
  logic [2:0]  status;
  cache_e      cache;
  logic        do_req, do_bind, do_restart;

  always_comb begin
    phase_d = phase_q;
    now_d = now_q;
    sent_d = sent_q;
    xid_d = xid_q;
    retry_d = retry_q;
    offered_d = offered_q;
    server_d = server_q;
    lease_d = lease_q;
    llen_d = llen_q;
    t1_d = t1_q;
    t2_d = t2_q;
    exp_d = exp_q;
    snd = 1'b0;
    kind = KindNone;
    s_req = '0;
    s_sid = '0;
    status = StRunning;
    cache = CacheNone;
    do_req = 1'b0;
    do_bind = 1'b0;
    do_restart = 1'b0;
    ph_emit = phase_q;

    unique case (cmd_i.op)
      OpTick, OpNop: begin
        if (cmd_i.op == OpTick) begin
          now_d = now_q + 1'b1;
        end
        status = (phase_q == PhLeased || phase_q == PhRenewing ||
                  phase_q == PhRebinding) ? StLeased : StRunning;
      end
      OpInit: begin
        xid_d = cfg_i.xid_seed;
        retry_d = '0;
        if (cfg_i.cached_ip != '0) begin
          lease_d = cfg_i.cached_ip;
          server_d = cfg_i.cached_sid;
          phase_d = PhRebooting;
          do_req = 1'b1;
        end else begin
          phase_d = PhInit;
          lease_d = '0;
        end
      end
      OpPoll: begin
        unique case (phase_q)
          PhInit: begin
            snd = 1'b1;
            kind = KindDiscover;
            phase_d = PhSelecting;
          end
          PhSelecting: begin
            if (cmd_i.offer) begin
              offered_d = cmd_i.offer_ip;
              server_d = cmd_i.offer_server;
              phase_d = PhRequesting;
              retry_d = '0;
              do_req = 1'b1;
            end else if (tmo_pace) begin
              retry_d = retry_inc;
              if (retry_inc >= cfg_i.retry_limit) begin
                do_restart = 1'b1;
                status = StFailed;
              end else begin
                snd = 1'b1;
                kind = KindDiscover;
              end
            end
          end
          PhRequesting: begin
            if (cmd_i.ack) begin
              if (cmd_i.ack_ip != lease_q && cmd_i.probe_in_use) begin
                snd = 1'b1;
                kind = KindDecline;
                s_req = cmd_i.ack_ip;
                s_sid = server_q;
                do_restart = 1'b1;
              end else begin
                do_bind = 1'b1;
              end
            end else if (cmd_i.nak) begin
              lease_d = '0;
              do_restart = 1'b1;
            end else if (tmo_pace) begin
              retry_d = retry_inc;
              if (retry_inc >= cfg_i.retry_limit) begin
                do_restart = 1'b1;
                status = StFailed;
              end else begin
                do_req = 1'b1;
              end
            end
          end
          PhRebooting: begin
            if (cmd_i.ack) begin
              do_bind = 1'b1;
            end else if (cmd_i.nak) begin
              cache = CacheForget;
              lease_d = '0;
              do_restart = 1'b1;
            end else if (tmo_pace) begin
              retry_d = retry_inc;
              if (retry_inc >= cfg_i.retry_limit) begin
                do_restart = 1'b1;
              end else begin
                do_req = 1'b1;
              end
            end
          end
          PhLeased: begin
            status = StLeased;
            if (now_q >= t2_q) begin
              xid_d = xid_q + 1'b1;
              phase_d = PhRebinding;
              ph_emit = PhRebinding;
              do_req = 1'b1;
            end else if (now_q >= t1_q) begin
              xid_d = xid_q + 1'b1;
              phase_d = PhRenewing;
              ph_emit = PhRenewing;
              do_req = 1'b1;
            end
          end
          PhRenewing, PhRebinding: begin
            if (cmd_i.ack) begin
              do_bind = 1'b1;
            end else if (cmd_i.nak) begin
              lease_d = '0;
              do_restart = 1'b1;
            end else if (now_q >= exp_q) begin
              do_restart = 1'b1;
            end else begin
              status = StLeased;
              if (phase_q == PhRenewing && now_q >= t2_q) begin
                phase_d = PhRebinding;
                ph_emit = PhRebinding;
                do_req = 1'b1;
              end else if (tmo_renew) begin
                do_req = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // a phase change from init lands before the request goes out
    if (cmd_i.op == OpInit) begin
      ph_emit = phase_d;
    end else if (cmd_i.op == OpPoll && phase_q == PhSelecting && cmd_i.offer) begin
      ph_emit = PhRequesting;
    end

    if (do_req) begin
      snd = 1'b1;
      kind = KindRequest;
      if (ph_emit == PhRequesting) begin
        s_req = offered_d;
        s_sid = server_d;
      end else if (ph_emit == PhRebooting) begin
        s_req = lease_d;
      end
    end

    if (do_bind) begin
      lease_d = cmd_i.ack_ip;
      if (cmd_i.ack_has_server) begin
        server_d = cmd_i.ack_server;
      end
      llen_d = b_len;
      t1_d = b_t1;
      t2_d = b_t2;
      exp_d = b_exp;
      phase_d = PhLeased;
      retry_d = '0;
      cache = CacheSave;
      status = b_status;
    end

    res.status = status;
    res.send_kind = kind;
    res.broadcast_flag = snd && !(kind == KindRequest && ph_emit == PhRenewing);
    res.unicast_to_server = snd && kind == KindRequest && ph_emit == PhRenewing &&
                            server_d != AllOnes;
    res.client_ip_field = (snd && (ph_emit == PhRenewing || ph_emit == PhRebinding)) ?
                          lease_d : '0;
    res.requested_ip_option = s_req;
    res.server_id_option = s_sid;
    // a sent message carries the xid from before a restart advances it; a restart with no send reports the advanced xid
    res.transaction_id = (snd || !do_restart) ? xid_d : xid_q + 1'b1;
    if (snd && kind != KindDecline) begin
      sent_d = now_q;
    end
    if (do_restart) begin
      xid_d = xid_q + 1'b1;
      phase_d = PhInit;
      retry_d = '0;
      if (!snd) begin
        res.transaction_id = xid_d;
      end
    end
    res.bound_ip = lease_d;
    res.cache_action = cache;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhInit;
      now_q <= '0;
      sent_q <= '0;
      xid_q <= '0;
      retry_q <= '0;
      offered_q <= '0;
      server_q <= '0;
      lease_q <= '0;
      llen_q <= '0;
      t1_q <= '0;
      t2_q <= '0;
      exp_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        now_q <= now_d;
        sent_q <= sent_d;
        xid_q <= xid_d;
        retry_q <= retry_d;
        offered_q <= offered_d;
        server_q <= server_d;
        lease_q <= lease_d;
        llen_q <= llen_d;
        t1_q <= t1_d;
        t2_q <= t2_d;
        exp_q <= exp_d;
      end
      if (take) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

endmodule

FILE: sv/dhcp_client_lease_machine_unit.sv
// DHCP client lease machine. Every input transaction (tick, poll, init or nop)
// yields exactly one result transaction. An item passes a command queue of
// QueueDepth entries (two by default) and is then executed by the lease state
// machine, so a new item is accepted every cycle while the output register
// drains; the result is registered when the back end takes the queued command.
// Registers are on an APB-style port at byte address 4*i and should be
// written while idle.
module dhcp_client_lease_machine_unit #(
  parameter int unsigned QueueDepth = dhcpc_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dhcpc_pkg::CfgAw-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dhcpc_pkg::in_item_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dhcpc_pkg::out_item_t        out_data_o
);
  import dhcpc_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  reg_e idx;

  assign pready = 1'b1;
  assign idx = reg_e'(paddr[CfgAw-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xid_seed <= '0;
      cfg_q.cached_ip <= '0;
      cfg_q.cached_sid <= '0;
      cfg_q.retry_limit <= 4'd3;
      cfg_q.renew_resend <= 8'd8;
      cfg_q.default_lease <= DefaultLease;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegXidSeed: cfg_q.xid_seed <= pwdata;
        RegCachedIp: cfg_q.cached_ip <= pwdata;
        RegCachedSid: cfg_q.cached_sid <= pwdata;
        RegRetryLimit: cfg_q.retry_limit <= pwdata[3:0];
        RegRenewResend: cfg_q.renew_resend <= pwdata[7:0];
        RegDefaultLease: cfg_q.default_lease <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegXidSeed: prdata = cfg_q.xid_seed;
      RegCachedIp: prdata = cfg_q.cached_ip;
      RegCachedSid: prdata = cfg_q.cached_sid;
      RegRetryLimit: prdata = {28'd0, cfg_q.retry_limit};
      RegRenewResend: prdata = {24'd0, cfg_q.renew_resend};
      RegDefaultLease: prdata = cfg_q.default_lease;
      default: prdata = '0;
    endcase
  end

  dhcpc_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  dhcpc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .out_data_o
  );

`ifndef ASSERT_OFF
  a_cmd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> out_valid_o) else $error("command gave no result");
  a_no_send_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.send_kind == KindNone) |->
    (!out_data_o.broadcast_flag && !out_data_o.unicast_to_server))
    else $error("flags without send");
  a_save_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.cache_action == CacheSave) |->
    (out_data_o.status != StRunning && out_data_o.status != StFailed))
    else $error("save without bind");
`endif

endmodule

FILE: bench/tb_top.sv
// self-checking bench for dhcp_client_lease_machine_unit: directed and random
// tick/poll/init traffic, apb register setup per phase, shadow lease machine
// depends on dhcpc_pkg (sv/dhcpc_pkg.sv) and the rtl top level
module tb_top;
  import dhcpc_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned ItemsPerPhase = 480;

  logic clk = 1'b1;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAw-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;

  dhcp_client_lease_machine_unit dut (.clk_i(clk), .*);

  always begin
    #1 clk = 1'b0;
    #1 clk = 1'b1;
  end

  in_item_t stimulus_fifo[$];
  out_item_t pending_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit in_fire = 1'b0;

  // shadow copy of the lease machine
  cfg_t cfg;
  phase_e ph;
  logic [31:0] now_s, last_sent, xid, offered, server, lease, lease_len;
  logic [31:0] renew_at, rebind_at, expire_at;
  logic [3:0] retries;
  out_item_t msg;
  bit sent;
  cache_e cache_act;

  function void send_msg(kind_e k, logic [31:0] req, logic [31:0] sid);
    sent = 1'b1;
    msg.send_kind = k;
    msg.broadcast_flag = !(k == KindRequest && ph == PhRenewing);
    msg.unicast_to_server = k == KindRequest && ph == PhRenewing && server != AllOnes;
    msg.client_ip_field = (ph == PhRenewing || ph == PhRebinding) ? lease : 32'd0;
    msg.requested_ip_option = req;
    msg.server_id_option = sid;
    msg.transaction_id = xid;
    if (k != KindDecline) last_sent = now_s;
  endfunction

  function void issue_request();
    if (ph == PhRequesting) send_msg(KindRequest, offered, server);
    else if (ph == PhRebooting) send_msg(KindRequest, lease, 32'd0);
    else send_msg(KindRequest, 32'd0, 32'd0);
  endfunction

  function logic [31:0] pace_secs();
    if (retries == 4'd0) return 32'd1;
    if (retries == 4'd1) return 32'd2;
    return 32'd4;
  endfunction

  function bit timed_out(logic [31:0] lim);
    logic [31:0] d;
    d = now_s - last_sent;
    return d >= lim;
  endfunction

  function bit retries_spent();
    retries = retries + 4'd1;
    return retries >= cfg.retry_limit;
  endfunction

  function void start_over();
    xid = xid + 32'd1;
    ph = PhInit;
    retries = 4'd0;
  endfunction

  function status_e take_lease(in_item_t it);
    bit changed, first;
    changed = lease != 0 && lease != it.ack_ip;
    first = lease == 0;
    lease = it.ack_ip;
    if (it.ack_has_server) server = it.ack_server;
    lease_len = (it.ack_lease != 0) ? it.ack_lease : cfg.default_lease;
    if (lease_len == InfiniteLease) begin
      renew_at = InfiniteLease;
      rebind_at = InfiniteLease;
      expire_at = InfiniteLease;
    end else begin
      renew_at = now_s + ((it.ack_t1 != 0) ? it.ack_t1 : lease_len / 2);
      rebind_at = now_s + ((it.ack_t2 != 0) ? it.ack_t2 : (lease_len / 8) * 7);
      expire_at = now_s + lease_len;
    end
    ph = PhLeased;
    retries = 4'd0;
    cache_act = CacheSave;
    if (changed) return StChanged;
    return first ? StAssigned : StLeased;
  endfunction

  function out_item_t lease_machine_step(in_item_t it);
    status_e st;
    logic offer, ack, nak;
    msg = '0;
    sent = 1'b0;
    cache_act = CacheNone;
    st = StRunning;
    offer = it.replies_seen[0];
    ack = it.replies_seen[1];
    nak = it.replies_seen[2];
    case (op_e'(it.opcode))
      OpPoll: begin
        case (ph)
          PhInit: begin
            send_msg(KindDiscover, 32'd0, 32'd0);
            ph = PhSelecting;
          end
          PhSelecting: begin
            if (offer) begin
              offered = it.offer_ip;
              server = it.offer_server;
              ph = PhRequesting;
              retries = 4'd0;
              issue_request();
            end else if (timed_out(pace_secs())) begin
              if (retries_spent()) begin
                start_over();
                st = StFailed;
              end else send_msg(KindDiscover, 32'd0, 32'd0);
            end
          end
          PhRequesting: begin
            if (ack) begin
              // conflict on a new address: decline and start over
              if (it.ack_ip != lease && it.probe_in_use) begin
                send_msg(KindDecline, it.ack_ip, server);
                start_over();
              end else st = take_lease(it);
            end else if (nak) begin
              lease = 32'd0;
              start_over();
            end else if (timed_out(pace_secs())) begin
              if (retries_spent()) begin
                start_over();
                st = StFailed;
              end else issue_request();
            end
          end
          PhRebooting: begin
            if (ack) st = take_lease(it);
            else if (nak) begin
              cache_act = CacheForget;
              lease = 32'd0;
              start_over();
            end else if (timed_out(pace_secs())) begin
              if (retries_spent()) start_over();
              else issue_request();
            end
          end
          PhLeased: begin
            st = StLeased;
            if (now_s >= rebind_at) begin
              xid = xid + 32'd1;
              ph = PhRebinding;
              issue_request();
            end else if (now_s >= renew_at) begin
              xid = xid + 32'd1;
              ph = PhRenewing;
              issue_request();
            end
          end
          PhRenewing, PhRebinding: begin
            if (ack) st = take_lease(it);
            else if (nak) begin
              lease = 32'd0;
              start_over();
            end else if (now_s >= expire_at) start_over();
            else begin
              st = StLeased;
              if (ph == PhRenewing && now_s >= rebind_at) begin
                ph = PhRebinding;
                issue_request();
              end else if (timed_out({24'd0, cfg.renew_resend})) issue_request();
            end
          end
          default: ;
        endcase
      end
      OpInit: begin
        xid = cfg.xid_seed;
        retries = 4'd0;
        if (cfg.cached_ip != 0) begin
          lease = cfg.cached_ip;
          server = cfg.cached_sid;
          ph = PhRebooting;
          issue_request();
        end else begin
          ph = PhInit;
          lease = 32'd0;
        end
      end
      default: begin
        if (it.opcode == OpTick) now_s = now_s + 32'd1;
        st = (ph == PhLeased || ph == PhRenewing || ph == PhRebinding) ? StLeased : StRunning;
      end
    endcase
    msg.status = st;
    if (!sent) msg.transaction_id = xid;
    msg.bound_ip = lease;
    msg.cache_action = cache_act;
    return msg;
  endfunction

  task automatic field_check(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
    end
  endtask

  // monitor: predicts on accepted input, checks accepted results
  always @(posedge clk) begin
    out_item_t e;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) pending_results.push_back(lease_machine_step(in_data_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
      end else begin
        e = pending_results.pop_front();
        field_check("status", 32'(e.status), 32'(out_data_o.status));
        field_check("send_kind", 32'(e.send_kind), 32'(out_data_o.send_kind));
        field_check("broadcast_flag", 32'(e.broadcast_flag),
                    32'(out_data_o.broadcast_flag));
        field_check("unicast_to_server", 32'(e.unicast_to_server),
                    32'(out_data_o.unicast_to_server));
        field_check("client_ip_field", e.client_ip_field, out_data_o.client_ip_field);
        field_check("requested_ip_option", e.requested_ip_option,
                    out_data_o.requested_ip_option);
        field_check("server_id_option", e.server_id_option, out_data_o.server_id_option);
        field_check("transaction_id", e.transaction_id, out_data_o.transaction_id);
        field_check("bound_ip", e.bound_ip, out_data_o.bound_ip);
        field_check("cache_action", 32'(e.cache_action), 32'(out_data_o.cache_action));
      end
    end
  end

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    logic nv;
    nv = in_valid_i && !in_fire;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) gap_left--;
      else if (stimulus_fifo.size() != 0) begin
        nv = 1'b1;
        in_data_i <= stimulus_fifo.pop_front();
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid_i <= nv;
  end

  // receiver: stall pattern is re-picked at random among three modes
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 50 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(reg_e r, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      RegXidSeed: cfg.xid_seed = v;
      RegCachedIp: cfg.cached_ip = v;
      RegCachedSid: cfg.cached_sid = v;
      RegRetryLimit: cfg.retry_limit = v[3:0];
      RegRenewResend: cfg.renew_resend = v[7:0];
      default: cfg.default_lease = v;
    endcase
  endtask

  task automatic wait_drained();
    while (stimulus_fifo.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_item_t make_item(op_e op, logic [2:0] replies);
    in_item_t it;
    it = '0;
    it.opcode = op;
    it.replies_seen = replies;
    return it;
  endfunction

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 9) < 8) return 32'h0A00_0000 | $urandom_range(1, 4);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 30);
    return $urandom;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.opcode = (r < 45) ? OpTick : (r < 90) ? OpPoll : (r < 96) ? OpInit : OpNop;
    it.replies_seen = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    it.offer_ip = pick_addr();
    it.offer_server = ($urandom_range(0, 9) == 0) ? AllOnes : pick_addr();
    it.ack_ip = pick_addr();
    it.ack_server = ($urandom_range(0, 9) == 0) ? AllOnes : pick_addr();
    it.ack_has_server = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 19);
    it.ack_lease = (r < 12) ? $urandom_range(2, 40) : (r < 15) ? 32'd0 :
                   (r < 17) ? InfiniteLease : $urandom;
    it.ack_t1 = pick_time();
    it.ack_t2 = pick_time();
    it.probe_in_use = ($urandom_range(0, 4) == 0);
    return it;
  endfunction

  initial begin
    in_item_t it;
    cfg = '{xid_seed: 32'd0, cached_ip: 32'd0, cached_sid: 32'd0, retry_limit: 4'd3,
            renew_resend: 8'd8, default_lease: DefaultLease};
    ph = PhInit;
    {now_s, last_sent, xid, offered, server, lease, lease_len} = '0;
    {renew_at, rebind_at, expire_at} = '0;
    retries = 4'd0;
    repeat (8) @(negedge clk);
    rst_ni = 1'b1;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          reg_write(RegXidSeed, 32'd0);
          reg_write(RegCachedIp, 32'd0);
          reg_write(RegCachedSid, 32'd0);
          reg_write(RegRetryLimit, 32'd3);
          reg_write(RegRenewResend, 32'd8);
          reg_write(RegDefaultLease, 32'd3600);
        end
        1: begin
          reg_write(RegXidSeed, 32'hFFFF_FFFF);
          reg_write(RegCachedIp, 32'h0A00_0002);
          reg_write(RegCachedSid, 32'h0A00_0001);
          reg_write(RegRetryLimit, 32'd1);
          reg_write(RegRenewResend, 32'd1);
          reg_write(RegDefaultLease, 32'd10);
        end
        2: begin
          reg_write(RegXidSeed, $urandom);
          reg_write(RegCachedIp, 32'd0);
          reg_write(RegCachedSid, 32'hFFFF_FFFF);
          reg_write(RegRetryLimit, 32'd15);
          reg_write(RegRenewResend, 32'd255);
          reg_write(RegDefaultLease, 32'hFFFF_FFFE);
        end
        default: begin
          // out of range retry limit: first timeout ends the phase
          reg_write(RegXidSeed, $urandom);
          reg_write(RegCachedIp, 32'hFFFF_FFFF);
          reg_write(RegCachedSid, $urandom);
          reg_write(RegRetryLimit, 32'd0);
          reg_write(RegRenewResend, 32'd3);
          reg_write(RegDefaultLease, 32'd1);
        end
      endcase

      if (p == 0) begin
        it = '1;
        it.opcode = OpNop;
        stimulus_fifo.push_back(it);
        stimulus_fifo.push_back(make_item(OpTick, 3'd0));
        stimulus_fifo.push_back(make_item(OpPoll, 3'd0));
        stimulus_fifo.push_back(make_item(OpPoll, 3'd0));
        it = make_item(OpPoll, 3'd1);
        it.offer_ip = 32'hFFFF_FFFF;
        it.offer_server = 32'hFFFF_FFFF;
        stimulus_fifo.push_back(it);
        // address conflict on the acked address
        it = make_item(OpPoll, 3'd2);
        it.ack_ip = 32'h0A00_0005;
        it.probe_in_use = 1'b1;
        stimulus_fifo.push_back(it);
        stimulus_fifo.push_back(make_item(OpPoll, 3'd0));
        it = make_item(OpPoll, 3'd1);
        it.offer_ip = 32'h0A00_0003;
        stimulus_fifo.push_back(it);
        stimulus_fifo.push_back(make_item(OpPoll, 3'd4));
        for (int k = 0; k < 4; k++) stimulus_fifo.push_back(make_item(OpTick, 3'd0));
        stimulus_fifo.push_back(make_item(OpPoll, 3'd0));
        it = make_item(OpPoll, 3'd1);
        it.offer_ip = 32'h0A00_0003;
        it.offer_server = 32'hFFFF_FFFF;
        stimulus_fifo.push_back(it);
        // short lease so renew and rebind come soon
        it = make_item(OpPoll, 3'd2);
        it.ack_ip = 32'h0A00_0003;
        it.ack_lease = 32'd8;
        stimulus_fifo.push_back(it);
        for (int k = 0; k < 5; k++) stimulus_fifo.push_back(make_item(OpTick, 3'd0));
        stimulus_fifo.push_back(make_item(OpPoll, 3'd0));
        it = make_item(OpPoll, 3'd2);
        it.ack_ip = 32'h0A00_0004;
        it.ack_lease = InfiniteLease;
        it.ack_has_server = 1'b1;
        it.ack_server = 32'h0A00_0001;
        stimulus_fifo.push_back(it);
        stimulus_fifo.push_back(make_item(OpInit, 3'd0));
      end
      for (int k = 0; k < ItemsPerPhase; k++) stimulus_fifo.push_back(random_item());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
